@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked on i_clk and disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants of the sorted min priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF       = 8;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = $clog2(DEPTH_DEF + 1);

    // Operation codes
    typedef enum logic [1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/spq_req_if.sv @@
// ---------------------------------------------------------------------------
// spq_req_if
// Request channel: operation code and value to insert.
// ---------------------------------------------------------------------------
interface spq_req_if
    import spq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic signed [VALUE_WIDTH-1:0] value_in;

    modport source (output valid, output cmd, output value_in, input ready);
    modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

@@ hw/rtl/spq_rsp_if.sv @@
// ---------------------------------------------------------------------------
// spq_rsp_if
// Response channel: read value, status and fill count.
// ---------------------------------------------------------------------------
interface spq_rsp_if
    import spq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value_out;
    logic [1:0]                    status;
    logic [COUNT_WIDTH-1:0]        fill_count;

    modport source (output valid, output value_out, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input value_out, input status, input fill_count,
                    output ready);
endinterface

@@ hw/rtl/sorted_min_priority_queue.sv @@
// ---------------------------------------------------------------------------
// sorted_min_priority_queue
// Min priority queue held as a sorted row of cells; head cell is smallest.
// ---------------------------------------------------------------------------
// One operation (enqueue, dequeue, peek) is accepted every clock cycle; its
// response appears in the output register on the next cycle. All cells of
// the row compare against the incoming value and shift in the same clock,
// so throughput is one transaction per cycle whatever the fill level, and
// the request side stalls only while a response waits unclaimed. Equal
// values leave in arrival order. Enqueue into a full queue returns status
// full, dequeue or peek on an empty queue returns status empty, both with a
// zero value; unused command codes return ok with the current fill count.
// ---------------------------------------------------------------------------
module sorted_min_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_value;
    logic [1:0]                    r_status;
    logic [CW-1:0]                 r_fill;

    logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
    logic                          cell_cmp [DEPTH];
    logic                          cell_occ [DEPTH];

    logic                          accept;
    logic                          full;
    logic                          empty;
    t_cell_ctrl                    ctrl;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic [1:0]                    n_status;

    // Accept while the response register is free or being drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CW'(DEPTH));
    assign empty       = (r_count == '0);

    // Decode the transaction
    always_comb begin
        ctrl     = '0;
        n_value  = '0;
        n_status = ST_OK;
        case (i_req.cmd)
            CMD_ENQ: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.enq = accept;
                end
            end
            CMD_DEQ: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctrl.deq = accept;
                    n_value  = cell_val[0];
                end
            end
            CMD_PEEK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_value = cell_val[0];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Advance the fill count
    always_comb begin
        n_count = r_count;
        if (ctrl.enq) begin
            n_count = r_count + CW'(1);
        end else if (ctrl.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Row of cells linked to their neighbors; the head has no left and the tail no right neighbor
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic signed [VALUE_WIDTH-1:0] left_val;
        logic                          left_cmp;
        logic signed [VALUE_WIDTH-1:0] right_val;

        assign cell_occ[gi] = (r_count > CW'(gi));

        if (gi == 0) begin : g_head
            assign left_val = '0;
            assign left_cmp = 1'b0;
        end else begin : g_body
            assign left_val = cell_val[gi-1];
            assign left_cmp = cell_cmp[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign right_val = '0;
        end else begin : g_inner
            assign right_val = cell_val[gi+1];
        end

        spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_value     (i_req.value_in),
            .i_occ       (cell_occ[gi]),
            .i_left_val  (left_val),
            .i_left_cmp  (left_cmp),
            .i_right_val (right_val),
            .o_val       (cell_val[gi]),
            .o_cmp       (cell_cmp[gi])
        );
    end

    // Response register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value  <= n_value;
            r_status <= n_status;
            r_fill   <= n_count;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.value_out  = r_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.fill_count = r_fill;

    // Checks
    `include "assert_macros.svh"

    `SPQ_ASSERT_IMP(a_count_max, 1'b1, r_count <= CW'(DEPTH))
    `SPQ_ASSERT_NXT(a_enq_grows, ctrl.enq, r_count == CW'($past(r_count) + CW'(1)))
    `SPQ_ASSERT_IMP(a_empty_fill, r_out_valid && r_status == ST_EMPTY, r_fill == '0)

    for (genvar gj = 0; gj < DEPTH - 1; gj++) begin : g_chk
        `SPQ_ASSERT_IMP(a_sorted, cell_occ[gj+1], cell_val[gj] <= cell_val[gj+1])
    end

endmodule

@@ hw/rtl/spq_cell.sv @@
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: compares the incoming value with its own entry
// and takes its new entry from itself, its left or right neighbor, or the
// incoming value.
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  t_cell_ctrl                    i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_occ,
    input  logic signed [VALUE_WIDTH-1:0] i_left_val,
    input  logic                          i_left_cmp,
    input  logic signed [VALUE_WIDTH-1:0] i_right_val,
    output logic signed [VALUE_WIDTH-1:0] o_val,
    output logic                          o_cmp
);

    logic signed [VALUE_WIDTH-1:0] r_val;
    logic signed [VALUE_WIDTH-1:0] n_val;

    // New value goes at or before this slot: slot empty or strictly larger
    assign o_cmp = !i_occ || (i_value < r_val);

    // Select next entry
    always_comb begin
        n_val = r_val;
        if (i_ctrl.enq) begin
            if (i_left_cmp) begin
                n_val = i_left_val;
            end else if (o_cmp) begin
                n_val = i_value;
            end
        end else if (i_ctrl.deq) begin
            n_val = i_right_val;
        end
    end

    // Hold entry
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
